/* rtl/mrbt_pkg.sv */
`default_nettype none
package mrbt_pkg;

	// Matrix geometry
	localparam int MAX_COLS    = 32;
	localparam int HEIGHT_BITS = 16;
	localparam int ROW_W       = 32;
	localparam int CFG_W       = 6;
	localparam int OUT_W       = 21;

	// Derived widths
	localparam int COL_W  = $clog2(MAX_COLS + 1);
	localparam int AREA_W = COL_W + HEIGHT_BITS;
	localparam int SAT_W  = (AREA_W > OUT_W) ? AREA_W : OUT_W;

	// Merge tree shape: lanes per group, then one final fold over groups
	localparam int GROUP_LANES = 8;
	localparam int NUM_GROUPS  = (MAX_COLS + GROUP_LANES - 1) / GROUP_LANES;

	localparam int COUNT_RESET = 32;

	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;
	localparam logic [OUT_W-1:0]       AREA_MAX   = '1;

	typedef logic [COL_W-1:0]       col_t;
	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [AREA_W-1:0]      area_t;
	typedef logic [OUT_W-1:0]       out_area_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic clear;
		logic en_s1;
		logic en_s2;
		col_t cols;
		col_t clear_cols;
	} lane_ctrl_t;

	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic valid_s3;
		logic last_s3;
		logic clear;
	} merge_ctrl_t;

	// Clamp a column count to the lanes that exist
	function automatic col_t cols_in_use(input logic [CFG_W-1:0] count);
		int c;
		c = int'(count);
		if (c > MAX_COLS)
			c = MAX_COLS;
		return COL_W'(c);
	endfunction

	// Saturate a lane area to the result width
	function automatic out_area_t sat_area(input area_t a);
		logic [SAT_W-1:0] wide;
		wide = SAT_W'(a);
		if (wide > SAT_W'(AREA_MAX))
			return AREA_MAX;
		return OUT_W'(wide);
	endfunction

endpackage
`default_nettype wire

/* rtl/mrbt_scan.sv */
`default_nettype none
module mrbt_scan (
	input  wire logic [mrbt_pkg::MAX_COLS-1:0] zero_mask,
	input  wire mrbt_pkg::col_t                cols,
	output mrbt_pkg::col_t                     left_edge  [mrbt_pkg::MAX_COLS],
	output mrbt_pkg::col_t                     right_edge [mrbt_pkg::MAX_COLS]
);

	// Left edge: one past the nearest zero cell to the left, else column 0
	always_comb begin
		for (int j = 0; j < mrbt_pkg::MAX_COLS; j++) begin
			left_edge[j] = '0;
			for (int k = 0; k < mrbt_pkg::MAX_COLS; k++) begin
				if (k < j && zero_mask[k])
					left_edge[j] = mrbt_pkg::COL_W'(k + 1);
			end
		end
	end

	// Right edge: nearest zero cell to the right, else the column count
	always_comb begin
		for (int j = 0; j < mrbt_pkg::MAX_COLS; j++) begin
			right_edge[j] = cols;
			for (int k = mrbt_pkg::MAX_COLS - 1; k >= 0; k--) begin
				if (k > j && zero_mask[k])
					right_edge[j] = mrbt_pkg::COL_W'(k);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/mrbt_lane.sv */
`default_nettype none
module mrbt_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mrbt_pkg::lane_ctrl_t ctrl,
	input  wire logic                 in_use,
	input  wire logic                 cell_one,
	input  wire mrbt_pkg::col_t       left_edge,
	input  wire mrbt_pkg::col_t       right_edge,
	output mrbt_pkg::area_t           area_s2
);

	mrbt_pkg::height_t height_q, height_new, height_s1;
	mrbt_pkg::col_t    left_q, left_new, left_s1;
	mrbt_pkg::col_t    right_q, right_new, right_s1;
	mrbt_pkg::col_t    width;

	// Next column state for this row
	always_comb begin
		if (cell_one) begin
			height_new = (height_q == mrbt_pkg::HEIGHT_MAX) ? height_q :
				height_q + mrbt_pkg::height_t'(1);
			left_new   = (left_q < left_edge) ? left_edge : left_q;
			right_new  = (right_q > right_edge) ? right_edge : right_q;
		end else begin
			height_new = '0;
			left_new   = '0;
			right_new  = ctrl.cols;
		end
	end

	// Hold column state; drop it after a final row or a count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
			left_q   <= '0;
			right_q  <= mrbt_pkg::cols_in_use(mrbt_pkg::CFG_W'(mrbt_pkg::COUNT_RESET));
		end else if (ctrl.clear) begin
			height_q <= '0;
			left_q   <= '0;
			right_q  <= ctrl.clear_cols;
		end else if (ctrl.accept) begin
			if (ctrl.last) begin
				height_q <= '0;
				left_q   <= '0;
				right_q  <= ctrl.cols;
			end else if (in_use) begin
				height_q <= height_new;
				left_q   <= left_new;
				right_q  <= right_new;
			end
		end
	end

	// Snapshot the updated column for the area stage
	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			height_s1 <= in_use ? height_new : '0;
			left_s1   <= left_new;
			right_s1  <= right_new;
		end
	end

	assign width = (right_s1 > left_s1) ? right_s1 - left_s1 : '0;

	// Area of this column's rectangle
	always_ff @(posedge clk) begin
		if (ctrl.en_s2)
			area_s2 <= mrbt_pkg::AREA_W'(width) * mrbt_pkg::AREA_W'(height_s1);
	end

endmodule
`default_nettype wire

/* rtl/mrbt_merge.sv */
`default_nettype none
module mrbt_merge (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mrbt_pkg::merge_ctrl_t ctrl,
	input  wire mrbt_pkg::area_t       area_s2 [mrbt_pkg::MAX_COLS],
	output mrbt_pkg::out_area_t        best_area_s4,
	output logic                       done_s4
);

	mrbt_pkg::out_area_t group_max [mrbt_pkg::NUM_GROUPS];
	mrbt_pkg::out_area_t group_max_s3 [mrbt_pkg::NUM_GROUPS];
	mrbt_pkg::out_area_t row_max;
	mrbt_pkg::out_area_t best_next;
	mrbt_pkg::out_area_t best_q;

	// Fold each group of lanes, saturated to the result width
	always_comb begin
		for (int g = 0; g < mrbt_pkg::NUM_GROUPS; g++) begin
			group_max[g] = '0;
			for (int k = 0; k < mrbt_pkg::GROUP_LANES; k++) begin
				if (g * mrbt_pkg::GROUP_LANES + k < mrbt_pkg::MAX_COLS) begin
					if (mrbt_pkg::sat_area(area_s2[g * mrbt_pkg::GROUP_LANES + k]) > group_max[g])
						group_max[g] = mrbt_pkg::sat_area(area_s2[g * mrbt_pkg::GROUP_LANES + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			for (int g = 0; g < mrbt_pkg::NUM_GROUPS; g++)
				group_max_s3[g] <= group_max[g];
		end
	end

	// Fold the groups and the running best
	always_comb begin
		row_max = '0;
		for (int g = 0; g < mrbt_pkg::NUM_GROUPS; g++) begin
			if (group_max_s3[g] > row_max)
				row_max = group_max_s3[g];
		end
		best_next = (row_max > best_q) ? row_max : best_q;
	end

	// Hold the running best; drop it after the final row of a matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctrl.clear) begin
			best_q <= '0;
		end else if (ctrl.en_s4 && ctrl.valid_s3) begin
			best_q <= ctrl.last_s3 ? '0 : best_next;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			best_area_s4 <= best_next;
			done_s4      <= ctrl.last_s3;
		end
	end

endmodule
`default_nettype wire

/* rtl/maximal_rectangle_bound_tracking.sv */
`default_nettype none
// Largest all-ones rectangle of a binary matrix fed one row per transfer. Each
// row is a 32-bit mask over the columns in use (column_count, max 32, reset 32;
// mask bits at or above the count are ignored). Every row gives exactly one
// result: the best area so far in the current matrix, saturated at 2^21-1, with
// matrix_done set on the result of the row marked final_row, after which all
// column state is cleared for the next matrix. One lane per column keeps the
// run height, left bound and right bound; the lanes update together on each
// accepted row, so the block takes one row per clock when the output is not
// stalled, and a result passes the snapshot, area, fold and output registers.
// The per-row column update is the loop that sets this rate. A write to
// column_count is always ready, takes effect in the next cycle, abandons any
// matrix in progress and must only be made while no row is in flight.
module maximal_rectangle_bound_tracking (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [mrbt_pkg::ROW_W-1:0]   row_bits,
	input  wire logic                         final_row,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [mrbt_pkg::OUT_W-1:0]        best_area,
	output logic                              matrix_done,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mrbt_pkg::CFG_W-1:0]   column_count
);

	logic [mrbt_pkg::CFG_W-1:0]    count_q;
	mrbt_pkg::col_t                cols;
	logic [mrbt_pkg::MAX_COLS-1:0] row_ext, in_use, cell_one, zero_mask;
	mrbt_pkg::col_t                left_edge  [mrbt_pkg::MAX_COLS];
	mrbt_pkg::col_t                right_edge [mrbt_pkg::MAX_COLS];
	mrbt_pkg::area_t               area_s2    [mrbt_pkg::MAX_COLS];
	mrbt_pkg::lane_ctrl_t          lane_ctrl;
	mrbt_pkg::merge_ctrl_t         merge_ctrl;
	logic                          valid_s1, valid_s2, valid_s3;
	logic                          last_s1, last_s2, last_s3;
	logic                          en_s1, en_s2, en_s3, en_s4;
	logic                          accept, cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Column count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= mrbt_pkg::CFG_W'(mrbt_pkg::COUNT_RESET);
		end else if (cfg_wr) begin
			count_q <= column_count;
		end
	end

	assign cols = mrbt_pkg::cols_in_use(count_q);

	// Stage enables: a stage advances when empty or when the next one advances
	assign en_s4    = !out_valid || !out_stall;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
			if (en_s4)
				out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			last_s1 <= final_row;
		if (en_s2)
			last_s2 <= last_s1;
		if (en_s3)
			last_s3 <= last_s2;
	end

	// Column masks: cells past the row width read as zero
	for (genvar j = 0; j < mrbt_pkg::MAX_COLS; j++) begin : g_mask
		if (j < mrbt_pkg::ROW_W) begin : g_row
			assign row_ext[j] = row_bits[j];
		end else begin : g_pad
			assign row_ext[j] = 1'b0;
		end
		assign in_use[j]    = mrbt_pkg::COL_W'(j) < cols;
		assign cell_one[j]  = in_use[j] && row_ext[j];
		assign zero_mask[j] = in_use[j] && !row_ext[j];
	end

	mrbt_scan u_scan (
		.zero_mask  (zero_mask),
		.cols       (cols),
		.left_edge  (left_edge),
		.right_edge (right_edge)
	);

	always_comb begin
		lane_ctrl.accept     = accept;
		lane_ctrl.last       = final_row;
		lane_ctrl.clear      = cfg_wr;
		lane_ctrl.en_s1      = en_s1;
		lane_ctrl.en_s2      = en_s2;
		lane_ctrl.cols       = cols;
		lane_ctrl.clear_cols = mrbt_pkg::cols_in_use(column_count);
	end

	for (genvar j = 0; j < mrbt_pkg::MAX_COLS; j++) begin : g_lane
		mrbt_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (lane_ctrl),
			.in_use     (in_use[j]),
			.cell_one   (cell_one[j]),
			.left_edge  (left_edge[j]),
			.right_edge (right_edge[j]),
			.area_s2    (area_s2[j])
		);
	end

	always_comb begin
		merge_ctrl.en_s3    = en_s3;
		merge_ctrl.en_s4    = en_s4;
		merge_ctrl.valid_s3 = valid_s3;
		merge_ctrl.last_s3  = last_s3;
		merge_ctrl.clear    = cfg_wr;
	end

	mrbt_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (merge_ctrl),
		.area_s2      (area_s2),
		.best_area_s4 (best_area),
		.done_s4      (matrix_done)
	);

endmodule
`default_nettype wire

/* rtl/mrbt_checker.sv */
`default_nettype none
module mrbt_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic [mrbt_pkg::OUT_W-1:0] best_area,
	input  wire logic                       matrix_done,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready
);

	logic       in_xfer, out_xfer;
	logic [2:0] pending_q;
	logic       prev_valid_q, prev_done_q;
	logic [mrbt_pkg::OUT_W-1:0] prev_area_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Track rows in flight and the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			prev_valid_q <= 1'b0;
			prev_done_q  <= 1'b0;
			prev_area_q  <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
			if (cfg_valid && cfg_ready)
				prev_valid_q <= 1'b0;
			else if (out_xfer) begin
				prev_valid_q <= 1'b1;
				prev_done_q  <= matrix_done;
				prev_area_q  <= best_area;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(best_area) && $stable(matrix_done))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an accepted row");

	a_idle_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> !in_stall)
		else $error("empty pipeline stalls input");

	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && prev_valid_q && !prev_done_q |-> best_area >= prev_area_q)
		else $error("best area shrank within a matrix");

endmodule

bind maximal_rectangle_bound_tracking mrbt_checker u_mrbt_checker (.*);
`default_nettype wire
